// ===== hdl/nfos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfos_pkg
// Shared types and constants of the NAND flash operation sequencer.
// ----------------------------------------------------------------------------
package nfos_pkg;

  localparam int PAGE_BYTES_DEF      = 2048;
  localparam int SECTOR_BYTES_DEF    = 512;
  localparam int PAGES_PER_BLOCK_DEF = 64;

  typedef enum logic [2:0] {
    F_LOAD   = 3'd0,
    F_FETCH  = 3'd1,
    F_RDSEC  = 3'd2,
    F_RDPAGE = 3'd3,
    F_PROG   = 3'd4,
    F_ERASE  = 3'd5,
    F_TICK   = 3'd6,
    F_RESET  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD1   = 3'd1,
    PH_ADDR   = 3'd2,
    PH_CMD2   = 3'd3,
    PH_WAIT   = 3'd4,
    PH_DATA   = 3'd5,
    PH_CMDST  = 3'd6,
    PH_STATUS = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_CMD     = 3'd1,
    K_ADDR    = 3'd2,
    K_WDATA   = 3'd3,
    K_RSTROBE = 3'd4
  } kind_t;

  localparam logic [7:0] CMD_READ1   = 8'h00;
  localparam logic [7:0] CMD_READ2   = 8'h30;
  localparam logic [7:0] CMD_PROG1   = 8'h80;
  localparam logic [7:0] CMD_PROG2   = 8'h10;
  localparam logic [7:0] CMD_ERASE1  = 8'h60;
  localparam logic [7:0] CMD_ERASE2  = 8'hD0;
  localparam logic [7:0] CMD_STATUS  = 8'h70;
  localparam logic [7:0] CMD_RESET   = 8'hFF;
  localparam logic [7:0] STATUS_FAIL = 8'h01;

endpackage

// ===== hdl/nand_flash_op_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nand_flash_op_sequencer_core
// Large-page NAND operation sequencer with a page buffer memory.
// ----------------------------------------------------------------------------
// channel | ports                                          | dir
// in      | in_valid/in_ready, in_func .. in_flash_byte     | input
// out     | out_valid/out_ready, out_cycle_kind .. busy_res | output
//
// One item per cycle while in_ready is high; each item gives exactly one
// result item. After acceptance, the page buffer read (fetch, program data)
// is registered with stage 1, then the result sits in an output register.
// in_ready is low only while the output register is full and not taken and
// the pipeline stage behind it is occupied. Reset clears the sequencer state,
// not the page buffer.
// ----------------------------------------------------------------------------
module nand_flash_op_sequencer_core #(
  parameter int PAGE_BYTES      = nfos_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES    = nfos_pkg::SECTOR_BYTES_DEF,
  parameter int PAGES_PER_BLOCK = nfos_pkg::PAGES_PER_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [17:0] in_sector,
  input  logic [9:0]  in_block_number,
  input  logic [10:0] in_buf_index,
  input  logic [7:0]  in_host_byte,
  input  logic        in_flash_ready,
  input  logic [7:0]  in_flash_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_cycle_kind,
  output logic [7:0]  out_bus_byte,
  output logic [7:0]  out_host_data,
  output logic        out_host_valid,
  output logic        out_op_done,
  output logic        out_op_failed,
  output logic        out_busy_res
);
  import nfos_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES);
  localparam int SW = AW + 1;
  localparam int SPP = PAGE_BYTES / SECTOR_BYTES;
  localparam int SPW = (SPP > 1) ? $clog2(SPP) : 1;
  localparam int SBW = $clog2(SECTOR_BYTES);
  localparam int PBW = $clog2(PAGES_PER_BLOCK);

  // sequencer state
  phase_t      phase_r, phase_nxt;
  func_t       op_r, op_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  // stage 1: result minus buffer read data
  logic        s1_v_r;
  kind_t       s1_kind_r;
  logic [7:0]  s1_bus_r, s1_host_r;
  logic        s1_hv_r, s1_done_r, s1_fail_r, s1_busy_r, s1_usemem_r;
  kind_t       kind_c;
  logic [7:0]  bus_c, host_c;
  logic        hv_c, done_c, fail_c, usemem_c;

  logic [7:0]  mem [PAGE_BYTES];
  logic [7:0]  rdata_r;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic        adv, acc;
  logic [1:0]  an;
  logic [SW-1:0] n_bytes;

  // output register
  logic        o_v_r;

  assign adv      = !s1_v_r || !o_v_r || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;
  assign n_bytes  = (op_r == F_RDSEC) ? SW'(SECTOR_BYTES) : SW'(PAGE_BYTES);

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    step_nxt  = step_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    kind_c    = K_NONE;
    bus_c     = 8'h00;
    host_c    = 8'h00;
    hv_c      = 1'b0;
    done_c    = 1'b0;
    fail_c    = 1'b0;
    usemem_c  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = AW'(in_buf_index);
    mem_ra    = AW'(in_buf_index);
    mem_wd    = in_host_byte;
    an        = 2'(step_r[1:0] + ((op_r == F_ERASE) ? 2'd2 : 2'd0));
    unique case (func_t'(in_func))
      F_LOAD: mem_we = acc;
      F_FETCH: begin
        mem_re   = acc;
        hv_c     = 1'b1;
        usemem_c = 1'b1;
      end
      F_TICK: begin
        unique case (phase_r)
          PH_CMD1: begin
            kind_c = K_CMD;
            if (op_r == F_RESET) begin
              bus_c     = CMD_RESET;
              done_c    = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              bus_c = (op_r == F_PROG) ? CMD_PROG1 :
                      (op_r == F_ERASE) ? CMD_ERASE1 : CMD_READ1;
              phase_nxt = PH_ADDR;
              step_nxt  = '0;
            end
          end
          PH_ADDR: begin
            kind_c = K_ADDR;
            case (an)
              2'd0:    bus_c = col_r[7:0];
              2'd1:    bus_c = col_r[15:8];
              2'd2:    bus_c = row_r[7:0];
              default: bus_c = row_r[15:8];
            endcase
            step_nxt = step_r + SW'(1);
            if (step_r + SW'(1) >= ((op_r == F_ERASE) ? SW'(2) : SW'(4))) begin
              step_nxt  = '0;
              phase_nxt = (op_r == F_PROG) ? PH_DATA : PH_CMD2;
            end
          end
          PH_CMD2: begin
            kind_c = K_CMD;
            bus_c  = (op_r == F_PROG) ? CMD_PROG2 :
                     (op_r == F_ERASE) ? CMD_ERASE2 : CMD_READ2;
            phase_nxt = PH_WAIT;
          end
          PH_WAIT: begin
            if (in_flash_ready) begin
              step_nxt  = '0;
              phase_nxt = (op_r == F_PROG || op_r == F_ERASE) ? PH_CMDST : PH_DATA;
            end
          end
          PH_DATA: begin
            mem_ra = step_r[AW-1:0];
            mem_wa = step_r[AW-1:0];
            mem_wd = in_flash_byte;
            if (op_r == F_PROG) begin
              kind_c   = K_WDATA;
              usemem_c = 1'b1;
              mem_re   = acc;
            end else begin
              kind_c = K_RSTROBE;
              if (op_r == F_RDSEC) begin
                host_c = in_flash_byte;
                hv_c   = 1'b1;
              end else begin
                mem_we = acc;
              end
            end
            step_nxt = step_r + SW'(1);
            if (step_r + SW'(1) >= n_bytes) begin
              step_nxt = '0;
              if (op_r == F_PROG) begin
                phase_nxt = PH_CMD2;
              end else begin
                done_c    = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_CMDST: begin
            kind_c    = K_CMD;
            bus_c     = CMD_STATUS;
            phase_nxt = PH_STATUS;
          end
          PH_STATUS: begin
            kind_c    = K_RSTROBE;
            done_c    = 1'b1;
            fail_c    = |(in_flash_byte & STATUS_FAIL);
            phase_nxt = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: begin
        if (phase_r == PH_IDLE) begin
          op_nxt   = func_t'(in_func);
          step_nxt = '0;
          if (func_t'(in_func) == F_ERASE) begin
            row_nxt = 16'({in_block_number, {PBW{1'b0}}});
          end else if (func_t'(in_func) != F_RESET) begin
            col_nxt = 16'({in_sector[SPW-1:0], {SBW{1'b0}}} & ((SPP > 1) ? '1 : '0));
            row_nxt = 16'(in_sector >> SPW);
            if (SPP == 1) row_nxt = 16'(in_sector);
          end
          phase_nxt = PH_CMD1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= F_LOAD;
      step_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      s1_v_r  <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        op_r    <= op_nxt;
        step_r  <= step_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
      end
      if (adv) begin
        s1_v_r <= acc;
        if (s1_v_r) o_v_r <= 1'b1;
        else if (out_ready) o_v_r <= 1'b0;
      end else if (out_ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r   <= kind_c;
      s1_bus_r    <= bus_c;
      s1_host_r   <= host_c;
      s1_hv_r     <= hv_c;
      s1_done_r   <= done_c;
      s1_fail_r   <= fail_c;
      s1_busy_r   <= (phase_nxt != PH_IDLE);
      s1_usemem_r <= usemem_c;
    end
    if (adv && s1_v_r) begin
      out_cycle_kind <= s1_kind_r;
      out_bus_byte   <= (s1_usemem_r && s1_kind_r == K_WDATA) ? rdata_r : s1_bus_r;
      out_host_data  <= (s1_usemem_r && s1_kind_r == K_NONE) ? rdata_r : s1_host_r;
      out_host_valid <= s1_hv_r;
      out_op_done    <= s1_done_r;
      out_op_failed  <= s1_fail_r;
      out_busy_res   <= s1_busy_r;
    end
  end

  assign out_valid = o_v_r;

endmodule

// ===== tb/nfos_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfos_checker
// Watches both channels of the NAND sequencer, predicts every result item
// from the accepted input items and compares field by field, in order.
// ----------------------------------------------------------------------------
module nfos_checker
  import nfos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [17:0] in_sector,
  input  logic [9:0]  in_block_number,
  input  logic [10:0] in_buf_index,
  input  logic [7:0]  in_host_byte,
  input  logic        in_flash_ready,
  input  logic [7:0]  in_flash_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_cycle_kind,
  input  logic [7:0]  out_bus_byte,
  input  logic [7:0]  out_host_data,
  input  logic        out_host_valid,
  input  logic        out_op_done,
  input  logic        out_op_failed,
  input  logic        out_busy_res,
  output int          fail_count,
  output int          pending
);

  localparam int PAGE_B  = PAGE_BYTES_DEF;
  localparam int SECT_B  = SECTOR_BYTES_DEF;
  localparam int SECT_PP = PAGE_B / SECT_B;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] bus;
    logic [7:0] hdata;
    logic       hvalid;
    logic       done;
    logic       failed;
    logic       busy;
  } bus_cycle_t;

  bus_cycle_t cycle_q[$];

  phase_t      seq_phase;
  func_t       seq_op;
  logic [11:0] seq_step;
  logic [15:0] col_addr;
  logic [15:0] row_addr;
  logic [7:0]  page_mem [PAGE_B];

  function automatic logic [7:0] addr_byte_at(logic [11:0] n);
    logic [1:0] sel;
    sel = n[1:0] + ((seq_op == F_ERASE) ? 2'd2 : 2'd0);
    case (sel)
      2'd0: return col_addr[7:0];
      2'd1: return col_addr[15:8];
      2'd2: return row_addr[7:0];
      default: return row_addr[15:8];
    endcase
  endfunction

  task automatic bus_tick(input logic rdy, input logic [7:0] fb, inout bus_cycle_t r);
    int n;
    case (seq_phase)
      PH_CMD1: begin
        r.kind = K_CMD;
        if (seq_op == F_RESET) begin
          r.bus = CMD_RESET;
          r.done = 1'b1;
          seq_phase = PH_IDLE;
        end else begin
          r.bus = (seq_op == F_PROG) ? CMD_PROG1 :
                  (seq_op == F_ERASE) ? CMD_ERASE1 : CMD_READ1;
          seq_phase = PH_ADDR;
          seq_step = '0;
        end
      end
      PH_ADDR: begin
        r.kind = K_ADDR;
        r.bus = addr_byte_at(seq_step);
        seq_step++;
        if (seq_step >= ((seq_op == F_ERASE) ? 2 : 4)) begin
          seq_step = '0;
          seq_phase = (seq_op == F_PROG) ? PH_DATA : PH_CMD2;
        end
      end
      PH_CMD2: begin
        r.kind = K_CMD;
        r.bus = (seq_op == F_PROG) ? CMD_PROG2 :
                (seq_op == F_ERASE) ? CMD_ERASE2 : CMD_READ2;
        seq_phase = PH_WAIT;
      end
      PH_WAIT: begin
        if (rdy) begin
          seq_step = '0;
          seq_phase = (seq_op == F_PROG || seq_op == F_ERASE) ? PH_CMDST : PH_DATA;
        end
      end
      PH_DATA: begin
        n = (seq_op == F_RDSEC) ? SECT_B : PAGE_B;
        if (seq_op == F_PROG) begin
          r.kind = K_WDATA;
          r.bus = page_mem[seq_step % PAGE_B];
        end else begin
          r.kind = K_RSTROBE;
          if (seq_op == F_RDSEC) begin
            r.hdata = fb;
            r.hvalid = 1'b1;
          end else begin
            page_mem[seq_step % PAGE_B] = fb;
          end
        end
        seq_step++;
        if (seq_step >= n) begin
          seq_step = '0;
          if (seq_op == F_PROG) begin
            seq_phase = PH_CMD2;
          end else begin
            r.done = 1'b1;
            seq_phase = PH_IDLE;
          end
        end
      end
      PH_CMDST: begin
        r.kind = K_CMD;
        r.bus = CMD_STATUS;
        seq_phase = PH_STATUS;
      end
      PH_STATUS: begin
        r.kind = K_RSTROBE;
        r.done = 1'b1;
        r.failed = |(fb & STATUS_FAIL);
        seq_phase = PH_IDLE;
      end
      default: seq_phase = PH_IDLE;
    endcase
  endtask

  task automatic predict_cycle();
    bus_cycle_t r;
    func_t f;
    int unsigned idx;
    r = '0;
    f = func_t'(in_func);
    idx = in_buf_index % PAGE_B;
    if (f == F_LOAD) begin
      page_mem[idx] = in_host_byte;
    end else if (f == F_FETCH) begin
      r.hdata = page_mem[idx];
      r.hvalid = 1'b1;
    end else if (f == F_TICK) begin
      bus_tick(in_flash_ready, in_flash_byte, r);
    end else if (seq_phase == PH_IDLE) begin
      seq_op = f;
      seq_step = '0;
      if (f == F_ERASE) begin
        row_addr = 16'(in_block_number * PAGES_PER_BLOCK_DEF);
      end else if (f != F_RESET) begin
        col_addr = 16'((in_sector % SECT_PP) * SECT_B);
        row_addr = 16'(in_sector / SECT_PP);
      end
      seq_phase = PH_CMD1;
    end
    r.busy = (seq_phase != PH_IDLE);
    cycle_q.push_back(r);
  endtask

  task automatic compare_cycle();
    bus_cycle_t e;
    if (cycle_q.size() == 0) begin
      $error("result item with nothing expected");
      fail_count++;
      return;
    end
    e = cycle_q.pop_front();
    if (out_cycle_kind !== e.kind) begin
      $error("cycle_kind: expected %0d got %0d", e.kind, out_cycle_kind);
      fail_count++;
    end
    if (out_bus_byte !== e.bus) begin
      $error("bus_byte: expected %02h got %02h", e.bus, out_bus_byte);
      fail_count++;
    end
    if (out_host_data !== e.hdata) begin
      $error("host_data: expected %02h got %02h", e.hdata, out_host_data);
      fail_count++;
    end
    if (out_host_valid !== e.hvalid) begin
      $error("host_valid: expected %0b got %0b", e.hvalid, out_host_valid);
      fail_count++;
    end
    if (out_op_done !== e.done) begin
      $error("op_done: expected %0b got %0b", e.done, out_op_done);
      fail_count++;
    end
    if (out_op_failed !== e.failed) begin
      $error("op_failed: expected %0b got %0b", e.failed, out_op_failed);
      fail_count++;
    end
    if (out_busy_res !== e.busy) begin
      $error("busy_res: expected %0b got %0b", e.busy, out_busy_res);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    seq_phase = PH_IDLE;
    seq_op = F_LOAD;
    seq_step = '0;
    col_addr = '0;
    row_addr = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase = PH_IDLE;
      seq_op = F_LOAD;
      seq_step = '0;
      col_addr = '0;
      row_addr = '0;
    end else begin
      if (out_valid && out_ready) compare_cycle();
      if (in_valid && in_ready) predict_cycle();
    end
    pending = cycle_q.size();
  end

endmodule

// ===== tb/tb_nand_flash_op_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nand_flash_op_sequencer_core
// Drives directed and random host items into the NAND sequencer with bursty
// input and a stalling receiver; the checker module judges every result.
// ----------------------------------------------------------------------------
module tb_nand_flash_op_sequencer_core;
  import nfos_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [17:0] in_sector;
  logic [9:0]  in_block_number;
  logic [10:0] in_buf_index;
  logic [7:0]  in_host_byte;
  logic        in_flash_ready;
  logic [7:0]  in_flash_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_cycle_kind;
  logic [7:0]  out_bus_byte;
  logic [7:0]  out_host_data;
  logic        out_host_valid;
  logic        out_op_done;
  logic        out_op_failed;
  logic        out_busy_res;
  int          fail_count;
  int          pending;
  int          burst_left;
  bit          buf_filled;

  nand_flash_op_sequencer_core i_dut (.*);

  nfos_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: one long hold early on, then stall patterns that change per segment.
  initial begin
    int mode;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    repeat (300) @(posedge clk);
    repeat (400) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 120)) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input func_t f, input logic [17:0] sec, input logic [9:0] blk,
                           input logic [10:0] idx, input logic [7:0] hb,
                           input logic rdy, input logic [7:0] fb);
    int gap;
    in_valid        <= 1'b1;
    in_func         <= f;
    in_sector       <= sec;
    in_block_number <= blk;
    in_buf_index    <= idx;
    in_host_byte    <= hb;
    in_flash_ready  <= rdy;
    in_flash_byte   <= fb;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic tick_item(input logic rdy, input logic [7:0] fb);
    send_item(F_TICK, 18'($urandom), 10'($urandom), 11'($urandom), 8'($urandom), rdy, fb);
  endtask

  // Request one operation and tick it through; extra ticks land on an idle block.
  task automatic run_op(input func_t f, input logic [17:0] sec, input logic [9:0] blk);
    int n;
    case (f)
      F_RESET: n = 1;
      F_ERASE: n = 6;
      F_RDSEC: n = 6 + SECTOR_BYTES_DEF;
      F_RDPAGE: n = 6 + PAGE_BYTES_DEF;
      default: n = 8 + PAGE_BYTES_DEF;
    endcase
    send_item(f, sec, blk, 11'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
    repeat (n + 20) begin
      // fetches only once every buffer entry holds a byte
      if (buf_filled && $urandom_range(0, 49) == 0)
        send_item(F_FETCH, 18'($urandom), 10'($urandom), 11'($urandom), 8'($urandom),
                  1'($urandom), 8'($urandom));
      tick_item($urandom_range(0, 4) != 0, 8'($urandom));
    end
  endtask

  function automatic logic [17:0] pick_sector();
    case ($urandom_range(0, 3))
      0: return 18'h0;
      1: return 18'h3FFFF;
      default: return 18'($urandom);
    endcase
  endfunction

  initial begin
    int r;
    func_t f;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = F_TICK;
    in_sector = '0;
    in_block_number = '0;
    in_buf_index = '0;
    in_host_byte = '0;
    in_flash_ready = 1'b0;
    in_flash_byte = '0;
    burst_left = 0;
    buf_filled = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    tick_item(1'b1, 8'hFF);
    send_item(F_LOAD, 18'h0, 10'h0, 11'd0, 8'h00, 1'b0, 8'h00);
    send_item(F_LOAD, 18'h3FFFF, 10'h3FF, 11'd2047, 8'hFF, 1'b1, 8'hFF);
    send_item(F_FETCH, 18'h0, 10'h0, 11'd2047, 8'h00, 1'b0, 8'h00);
    send_item(F_FETCH, 18'h0, 10'h0, 11'd0, 8'hFF, 1'b1, 8'hFF);
    run_op(F_RESET, 18'h0, 10'h0);
    send_item(F_RDPAGE, 18'h3FFFF, 10'h0, 11'd0, 8'h00, 1'b0, 8'h00);
    send_item(F_ERASE, 18'h0, 10'h3FF, 11'd0, 8'h00, 1'b0, 8'h00);
    tick_item(1'b0, 8'h00);
    repeat (5) tick_item(1'b1, 8'hFF);
    repeat (3) tick_item(1'b0, 8'h00);
    repeat (PAGE_BYTES_DEF + 4) tick_item(1'b1, 8'($urandom));
    buf_filled = 1'b1;
    send_item(F_FETCH, 18'h0, 10'h0, 11'd5, 8'h00, 1'b0, 8'h00);
    run_op(F_PROG, 18'h0, 10'h0);
    run_op(F_ERASE, 18'h0, 10'h3FF);
    run_op(F_ERASE, 18'h3FFFF, 10'h0);
    run_op(F_RDSEC, 18'h3FFFF, 10'h0);

    // sender pause until the block has drained
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    // random part; the early receiver hold stalls the input during the directed part
    for (r = 0; r < 1250; r++) begin
      if ($urandom_range(0, 19) == 0) begin
        f = func_t'($urandom_range(2, 7));
        if (f == F_TICK) f = F_ERASE;
        if (f == F_RDPAGE || f == F_PROG || f == F_RDSEC)
          f = F_ERASE;
        run_op(f, pick_sector(), 10'($urandom));
      end else begin
        f = func_t'($urandom_range(0, 7));
        send_item(f, pick_sector(), 10'($urandom), 11'($urandom), 8'($urandom),
                  $urandom_range(0, 3) != 0, 8'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/nfos_pkg.sv
hdl/nand_flash_op_sequencer_core.sv
tb/nfos_checker.sv
tb/tb_nand_flash_op_sequencer_core.sv
